### sv/gn2d_pkg.sv
// Shared constants for the 2D gradient noise pipeline.
package gn2d_pkg;

    // Width of one coordinate field on the input stream.
    localparam int COORD_W = 24;
    // Width of the noise value on the output stream.
    localparam int NOISE_W = 16;

    // Corner hash multipliers.
    localparam logic [31:0] HASH_MX  = 32'd1836311903;
    localparam logic [31:0] HASH_MY  = 32'd2971215073;
    localparam logic [31:0] HASH_MIX = 32'h045d9f3b;

    // Odd Taylor coefficients of the quarter-wave sine, Q30, with pi/2 folded in.
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;

    // Phase is 16 bits per turn.
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

endpackage

### sv/gradient_noise_2d.sv
// Top level of the 2D gradient noise generator with stream ports and seed register.
//
// Takes one point per clock and returns one Q1.15 noise value per point, in order.
// The datapath is a fixed 20-stage pipeline, and when the output side never stalls a new
// point can be taken in every cycle. Each stage holds at most one multiplier level (corner
// hash rounds, the sine polynomial steps, the gradient dot products and the two smoothstep
// blends). When a finished value waits at the output and is not taken, the whole pipeline
// holds and s_axis_tready drops; otherwise input is taken even while results are in flight.
// The seed register should be written only while no point is in the pipeline.
module gradient_noise_2d
    import gn2d_pkg::*;
#(
    parameter int ANGLE_BITS = 10,
    parameter int FRAC_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] x_coord, [47:24] y_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] noise_value
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam int F   = FRAC_BITS;
    localparam int DW  = F + 18;
    localparam int EW  = DW + 1;
    localparam int BW  = EW + 17;
    localparam int NST = 20;
    localparam int FXD = 11;
    localparam int SXD = 12;
    localparam int SYD = 15;

    localparam logic signed [BW-1:0] HALF   = BW'(1) << (F - 1);
    localparam logic signed [BW-1:0] SAT_HI = BW'(32767);
    localparam logic signed [BW-1:0] SAT_LO = -BW'(32768);

    logic            en;
    logic [NST:1]    vld_reg;
    logic [31:0]     seed_reg;

    // Stage 1
    logic [31:0]     mx_reg, my_reg;
    logic [2*F-1:0]  ffx_reg, ffy_reg;
    logic [F+1:0]    tx_reg, ty_reg;
    logic [F-1:0]    fx_pipe_reg [FXD];
    logic [F-1:0]    fy_pipe_reg [FXD];
    // Stages 2 to 4
    logic [31:0]     hm_reg [4];
    logic [3*F+1:0]  numx_reg, numy_reg;
    logic [31:0]     p1_reg [4];
    logic [31:0]     p2_reg [4];
    logic [15:0]     sx_pipe_reg [SXD];
    logic [15:0]     sy_pipe_reg [SYD];
    // Stages 12 to 20
    logic signed [DW-1:0] px_reg [4];
    logic signed [DW-1:0] py_reg [4];
    logic signed [DW-1:0] dot_reg [4];
    logic signed [EW-1:0] df_reg [2];
    logic signed [DW-1:0] a0_reg [2];
    logic signed [BW-1:0] bp_reg [2];
    logic signed [DW-1:0] a0b_reg [2];
    logic signed [DW-1:0] row_reg [2];
    logic signed [EW-1:0] rd_reg;
    logic signed [DW-1:0] r0_reg;
    logic signed [BW-1:0] vp_reg;
    logic signed [DW-1:0] r0b_reg;
    logic signed [DW-1:0] v_reg;
    logic [15:0]          out_reg;

    // Combinational next values
    logic signed [COORD_W-1:0] x_in, y_in, x_fl, y_fl;
    logic [31:0]          cx0, cy0;
    logic [F-1:0]         fx_in, fy_in;
    logic [31:0]          mx_next, my_next;
    logic [2*F-1:0]       ffx_next, ffy_next;
    logic [F+1:0]         tx_next, ty_next;
    logic [31:0]          xp1, yp1, xpart, ypart, hraw;
    logic [31:0]          hm_next [4];
    logic [3*F+1:0]       numx_next, numy_next;
    logic [3*F+17:0]      wsx, wsy;
    logic [31:0]          p1_next [4];
    logic [31:0]          p2_next [4];
    logic [31:0]          hf [4];
    logic [ANGLE_BITS-1:0] idx [4];
    logic [15:0]          phase_x [4];
    logic [15:0]          phase_y [4];
    logic signed [16:0]   g_x [4];
    logic signed [16:0]   g_y [4];
    logic signed [F:0]    dx_s [4];
    logic signed [F:0]    dy_s [4];
    logic signed [DW-1:0] px_next [4];
    logic signed [DW-1:0] py_next [4];
    logic signed [DW-1:0] dot_next [4];
    logic signed [EW-1:0] df_next [2];
    logic signed [BW-1:0] bp_next [2];
    logic signed [BW-1:0] bsh [2];
    logic signed [BW-1:0] bsum [2];
    logic signed [EW-1:0] rd_next;
    logic signed [BW-1:0] vp_next;
    logic signed [BW-1:0] vsh, vsum, vrnd;
    logic [15:0]          out_next;

    // The pipeline advances unless a finished value sits at the output untaken.
    assign en            = !vld_reg[NST] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST];
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            seed_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-1:1], s_axis_tvalid};
        end
    end

    // Lattice split, hash rounds and smoothstep weights.
    always_comb
    begin
        x_in  = $signed(s_axis_tdata[COORD_W-1:0]);
        y_in  = $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);
        x_fl  = x_in >>> F;
        y_fl  = y_in >>> F;
        cx0   = {{(32-COORD_W){x_fl[COORD_W-1]}}, x_fl};
        cy0   = {{(32-COORD_W){y_fl[COORD_W-1]}}, y_fl};
        fx_in = s_axis_tdata[F-1:0];
        fy_in = s_axis_tdata[COORD_W+F-1:COORD_W];

        mx_next  = cx0 * HASH_MX;
        my_next  = cy0 * HASH_MY;
        ffx_next = (2*F)'(fx_in) * (2*F)'(fx_in);
        ffy_next = (2*F)'(fy_in) * (2*F)'(fy_in);
        tx_next  = (F+2)'(3) << F;
        tx_next  = tx_next - {1'b0, fx_in, 1'b0};
        ty_next  = (F+2)'(3) << F;
        ty_next  = ty_next - {1'b0, fy_in, 1'b0};

        // The next corner column and row only add the multiplier once more.
        xp1 = mx_reg + HASH_MX;
        yp1 = my_reg + HASH_MY;
        for (int c = 0; c < 4; c++)
        begin
            xpart      = c[0] ? xp1 : mx_reg;
            ypart      = c[1] ? yp1 : my_reg;
            hraw       = xpart ^ ypart ^ seed_reg;
            hm_next[c] = hraw ^ (hraw >> 16);
        end
        numx_next = (3*F+2)'(ffx_reg) * (3*F+2)'(tx_reg);
        numy_next = (3*F+2)'(ffy_reg) * (3*F+2)'(ty_reg);

        for (int c = 0; c < 4; c++)
        begin
            p1_next[c] = hm_reg[c] * HASH_MIX;
            p2_next[c] = (p1_reg[c] ^ (p1_reg[c] >> 16)) * HASH_MIX;
            hf[c]      = p2_reg[c] ^ (p2_reg[c] >> 16);
            idx[c]     = hf[c][31 -: ANGLE_BITS];
            phase_y[c] = {idx[c], {(16-ANGLE_BITS){1'b0}}};
            phase_x[c] = phase_y[c] + QUARTER_TURN;
        end

        // Smoothstep floored to Q16: drop 3*F fraction bits after scaling by 2^16.
        wsx = {numx_reg, 16'h0000};
        wsy = {numy_reg, 16'h0000};
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        gn2d_sine u_sine_x
        (
            .clk   (clk),
            .en    (en),
            .phase (phase_x[c]),
            .grad  (g_x[c])
        );

        gn2d_sine u_sine_y
        (
            .clk   (clk),
            .en    (en),
            .phase (phase_y[c]),
            .grad  (g_y[c])
        );
    end

    // Dot products and the two blend levels.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            // An offset to the far corner is the fraction minus one: a set sign bit.
            dx_s[c]     = $signed({c[0], fx_pipe_reg[FXD-1]});
            dy_s[c]     = $signed({c[1], fy_pipe_reg[FXD-1]});
            px_next[c]  = DW'(dx_s[c]) * DW'(g_x[c]);
            py_next[c]  = DW'(dy_s[c]) * DW'(g_y[c]);
            dot_next[c] = px_reg[c] + py_reg[c];
        end
        for (int r = 0; r < 2; r++)
        begin
            df_next[r] = EW'(dot_reg[2*r+1]) - EW'(dot_reg[2*r]);
            bp_next[r] = BW'(df_reg[r]) * BW'($signed({1'b0, sx_pipe_reg[SXD-1]}));
            bsh[r]     = bp_reg[r] >>> 16;
            bsum[r]    = BW'(a0b_reg[r]) + bsh[r];
        end
        rd_next = EW'(row_reg[1]) - EW'(row_reg[0]);
        vp_next = BW'(rd_reg) * BW'($signed({1'b0, sy_pipe_reg[SYD-1]}));
        vsh     = vp_reg >>> 16;
        vsum    = BW'(r0b_reg) + vsh;
        vrnd    = (BW'(v_reg) + HALF) >>> F;
        if (vrnd > SAT_HI)
        begin
            out_next = 16'h7fff;
        end
        else if (vrnd < SAT_LO)
        begin
            out_next = 16'h8000;
        end
        else
        begin
            out_next = vrnd[NOISE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            ffx_reg <= ffx_next;
            ffy_reg <= ffy_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            fx_pipe_reg[0] <= fx_in;
            fy_pipe_reg[0] <= fy_in;
            for (int i = 1; i < FXD; i++)
            begin
                fx_pipe_reg[i] <= fx_pipe_reg[i-1];
                fy_pipe_reg[i] <= fy_pipe_reg[i-1];
            end

            numx_reg <= numx_next;
            numy_reg <= numy_next;
            sx_pipe_reg[0] <= wsx[3*F+15:3*F];
            sy_pipe_reg[0] <= wsy[3*F+15:3*F];
            for (int i = 1; i < SXD; i++)
            begin
                sx_pipe_reg[i] <= sx_pipe_reg[i-1];
            end
            for (int i = 1; i < SYD; i++)
            begin
                sy_pipe_reg[i] <= sy_pipe_reg[i-1];
            end

            for (int c = 0; c < 4; c++)
            begin
                hm_reg[c]  <= hm_next[c];
                p1_reg[c]  <= p1_next[c];
                p2_reg[c]  <= p2_next[c];
                px_reg[c]  <= px_next[c];
                py_reg[c]  <= py_next[c];
                dot_reg[c] <= dot_next[c];
            end

            for (int r = 0; r < 2; r++)
            begin
                df_reg[r]  <= df_next[r];
                a0_reg[r]  <= dot_reg[2*r];
                bp_reg[r]  <= bp_next[r];
                a0b_reg[r] <= a0_reg[r];
                row_reg[r] <= $signed(bsum[r][DW-1:0]);
            end

            rd_reg  <= rd_next;
            r0_reg  <= row_reg[0];
            vp_reg  <= vp_next;
            r0b_reg <= r0_reg;
            v_reg   <= $signed(vsum[DW-1:0]);
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // A stalled pipeline keeps every item where it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // No new point may enter while a finished value waits untaken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the output is stalled");

    // The unit gradient of corner 0 stays within one in Q15.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[11] |-> (g_x[0] <= 17'sd32768 && g_x[0] >= -17'sd32768 &&
                         g_y[0] <= 17'sd32768 && g_y[0] >= -17'sd32768))
        else $error("gradient component out of range");
`endif

endmodule

### sv/gn2d_sine.sv
// Pipelined Q15 sine of a 16-bit phase: quadrant fold plus Horner polynomial.
module gn2d_sine
    import gn2d_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [16:0] grad
);

    logic [14:0]        u_reg [5];
    logic [30:0]        z2_reg [4];
    logic               neg_reg [6];
    logic [30:0]        term_reg [4];
    logic [30:0]        pz_reg;
    logic signed [16:0] grad_reg;

    logic [14:0]        u_next;
    logic [28:0]        uu;
    logic [30:0]        z2_next;
    logic [61:0]        prod2, prod3, prod4, prod5;
    logic [30:0]        acc3, acc4, acc5, acc6;
    logic [44:0]        prod6;
    logic [31:0]        rnd;
    logic [16:0]        mag;
    logic [16:0]        mag_c;
    logic signed [16:0] grad_next;

    always_comb
    begin
        // The second and fourth quadrants run the quarter wave backwards.
        u_next  = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
        uu      = 29'(u_next) * 29'(u_next);
        z2_next = {uu[28:0], 2'b00};

        prod2 = 62'(SIN_C9) * 62'(z2_reg[0]);
        acc3  = SIN_C7 - term_reg[0];
        prod3 = 62'(acc3) * 62'(z2_reg[1]);
        acc4  = SIN_C5 - term_reg[1];
        prod4 = 62'(acc4) * 62'(z2_reg[2]);
        acc5  = SIN_C3 - term_reg[2];
        prod5 = 62'(acc5) * 62'(z2_reg[3]);
        acc6  = SIN_C1 - term_reg[3];
        prod6 = 45'(acc6) * 45'(u_reg[4]);

        rnd   = {1'b0, pz_reg} + 32'd16384;
        mag   = rnd[31:15];
        mag_c = (mag > 17'd32768) ? 17'd32768 : mag;
        grad_next = neg_reg[5] ? -$signed(mag_c) : $signed(mag_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0]   <= u_next;
            z2_reg[0]  <= z2_next;
            neg_reg[0] <= phase[15];
            for (int i = 1; i < 5; i++)
            begin
                u_reg[i] <= u_reg[i-1];
            end
            for (int i = 1; i < 4; i++)
            begin
                z2_reg[i] <= z2_reg[i-1];
            end
            for (int i = 1; i < 6; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
            term_reg[0] <= prod2[60:30];
            term_reg[1] <= prod3[60:30];
            term_reg[2] <= prod4[60:30];
            term_reg[3] <= prod5[60:30];
            pz_reg      <= prod6[44:14];
            grad_reg    <= grad_next;
        end
    end

    assign grad = grad_reg;

endmodule
